>>> rtl/periodic_task_deadline_dispatcher_macros.svh
// Assertion macros for the periodic task deadline dispatcher.
// Used by the port checker; no other dependencies.
`ifndef PERIODIC_TASK_DEADLINE_DISPATCHER_MACROS_SVH
`define PERIODIC_TASK_DEADLINE_DISPATCHER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define PTDD_ASSERT_NOW(label, ck, rs, a, b) \
  label: assert property (@(posedge ck) disable iff (rs) (a) |-> (b)) \
    else $error("ptdd port check failed");

// Next-cycle implication, disabled during reset.
`define PTDD_ASSERT_NEXT(label, ck, rs, a, b) \
  label: assert property (@(posedge ck) disable iff (rs) (a) |=> (b)) \
    else $error("ptdd port check failed");

`endif

>>> rtl/ptdd_pkg.sv
// Shared types and constants for the periodic task deadline dispatcher.
// No dependencies.
package ptdd_pkg;

  localparam int TASK_COUNT_DEFAULT = 64;
  localparam int IDX_W              = 6;
  localparam int TIME_W             = 32;

  typedef enum logic [2:0] {
    OP_TICK    = 3'd0,
    OP_SET     = 3'd1,
    OP_CLEAR   = 3'd2,
    OP_SUSPEND = 3'd3,
    OP_RESUME  = 3'd4,
    OP_REPORT  = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH
  } state_t;

  // Table request broadcast to every cell
  typedef struct packed {
    logic              apply;
    op_t               op;
    logic              single;
    logic              all;
    logic [6:0]        index;
    logic [TIME_W-1:0] period;
    logic [TIME_W-1:0] now;
    logic              keep;
  } cell_cmd_t;

endpackage

>>> rtl/periodic_task_deadline_dispatcher.sv
// Periodic task deadline dispatcher: request channel in, fired-task strobe out.
// Holds the controller and a chain of TASK_COUNT task cells.
// Depends on ptdd_pkg, ptdd_ctrl and ptdd_cell.
//
// Usage:
//   A request (command, task_index, period, now, keep_enabled) is taken at a
//   rising edge with start high and busy low.
//   Set, clear, suspend, resume and report update the table in the cycle
//   they are taken; busy stays low and the next request may follow at once.
//   A tick raises busy while a scan token walks the cell chain one cell per
//   cycle, then a flush state ends the tick. Each due
//   task appears on fired_task with fired high for exactly one cycle, in
//   index order; last marks the final one of the tick. A tick with nothing
//   due shows no strobe. Each hit is held back and registered before it
//   shows; the final one lands in the cycle busy drops.
//   The receiver cannot stall: each strobe is taken in its own cycle.
//   Synchronous reset clears every task entry and the scan at once.
module periodic_task_deadline_dispatcher import ptdd_pkg::*; #(
  parameter int TASK_COUNT = TASK_COUNT_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [2:0]        command,
  input  logic [6:0]        task_index,
  input  logic [TIME_W-1:0] period,
  input  logic [TIME_W-1:0] now,
  input  logic              keep_enabled,
  output logic              fired,
  output logic [IDX_W-1:0]  fired_task,
  output logic              last
);

  cell_cmd_t             cell_cmd;
  logic [TIME_W-1:0]     tick_now;
  logic                  tok0;
  logic [TASK_COUNT:0]   tok;
  logic [TASK_COUNT-1:0] hit_vec;

  assign tok[0] = tok0;

  ptdd_ctrl #(.TASK_COUNT(TASK_COUNT)) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .command      (command),
    .task_index   (task_index),
    .period       (period),
    .now          (now),
    .keep_enabled (keep_enabled),
    .hit_any      (|hit_vec),
    .busy         (busy),
    .cell_cmd     (cell_cmd),
    .tick_now     (tick_now),
    .tok0         (tok0),
    .fired        (fired),
    .fired_task   (fired_task),
    .last         (last)
  );

  for (genvar i = 0; i < TASK_COUNT; i++) begin : g_cell
    ptdd_cell #(.INDEX(i)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .cmd      (cell_cmd),
      .tick_now (tick_now),
      .tok_in   (tok[i]),
      .tok_out  (tok[i+1]),
      .hit      (hit_vec[i])
    );
  end

endmodule

>>> rtl/ptdd_cell.sv
// One task entry: enable, record, period, due time and the scan token stage.
// Depends on ptdd_pkg.
module ptdd_cell import ptdd_pkg::*; #(
  parameter int INDEX = 0
) (
  input  logic              clk,
  input  logic              rst,
  input  cell_cmd_t         cmd,
  input  logic [TIME_W-1:0] tick_now,
  input  logic              tok_in,
  output logic              tok_out,
  output logic              hit
);

  logic              token;
  logic              enabled;
  logic              record;
  logic [TIME_W-1:0] period;
  logic [TIME_W-1:0] due;
  logic              mine;

  assign mine    = cmd.single && (cmd.index == 7'(INDEX));
  assign hit     = token && enabled && (tick_now >= due);
  assign tok_out = token;

  always_ff @(posedge clk) begin
    if (rst) begin
      token   <= 1'b0;
      enabled <= 1'b0;
      record  <= 1'b0;
      period  <= '0;
      due     <= '0;
    end else begin
      token <= tok_in;
      if (hit) begin
        due <= tick_now + period;
      end
      if (cmd.apply) begin
        case (cmd.op)
          OP_SET: begin
            if (mine) begin
              enabled <= 1'b1;
              period  <= cmd.period;
              due     <= cmd.now + cmd.period;
            end
          end
          OP_CLEAR: begin
            if (mine) enabled <= 1'b0;
          end
          OP_SUSPEND: begin
            if (mine) begin
              enabled <= 1'b0;
            end else if (cmd.all && enabled) begin
              record  <= 1'b1;
              enabled <= 1'b0;
            end
          end
          OP_RESUME: begin
            if (mine) begin
              enabled <= 1'b1;
            end else if (cmd.all && record) begin
              record  <= 1'b0;
              enabled <= 1'b1;
            end
          end
          OP_REPORT: begin
            if (mine) enabled <= cmd.keep;
          end
          default: begin
          end
        endcase
      end
    end
  end

endmodule

>>> rtl/ptdd_ctrl.sv
// Request decode, tick scan sequencer and fired-task output registers.
// Depends on ptdd_pkg.
module ptdd_ctrl import ptdd_pkg::*; #(
  parameter int TASK_COUNT = TASK_COUNT_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [2:0]        command,
  input  logic [6:0]        task_index,
  input  logic [TIME_W-1:0] period,
  input  logic [TIME_W-1:0] now,
  input  logic              keep_enabled,
  input  logic              hit_any,
  output logic              busy,
  output cell_cmd_t         cell_cmd,
  output logic [TIME_W-1:0] tick_now,
  output logic              tok0,
  output logic              fired,
  output logic [IDX_W-1:0]  fired_task,
  output logic              last
);

  state_t             state, state_next;
  logic [IDX_W-1:0]   scan_idx, scan_idx_next;
  logic               have_held, have_held_next;
  logic [IDX_W-1:0]   held_idx, held_idx_next;
  logic               fired_next, last_next;
  logic [IDX_W-1:0]   fired_task_next;
  logic               accept;
  op_t                op;

  assign op     = op_t'(command);
  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;
  assign tok0   = accept && (op == OP_TICK);

  always_comb begin
    cell_cmd.apply  = accept && (op != OP_TICK);
    cell_cmd.op     = op;
    cell_cmd.single = task_index < 7'(TASK_COUNT);
    cell_cmd.all    = task_index == 7'(TASK_COUNT);
    cell_cmd.index  = task_index;
    cell_cmd.period = period;
    cell_cmd.now    = now;
    cell_cmd.keep   = keep_enabled;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      scan_idx  <= '0;
      have_held <= 1'b0;
      fired     <= 1'b0;
    end else begin
      state     <= state_next;
      scan_idx  <= scan_idx_next;
      have_held <= have_held_next;
      fired     <= fired_next;
    end
  end

  always_ff @(posedge clk) begin
    held_idx   <= held_idx_next;
    fired_task <= fired_task_next;
    last       <= last_next;
    if (tok0) tick_now <= now;
  end

  // A hit is held back one step so the final one of a tick can carry last.
  always_comb begin
    state_next      = state;
    scan_idx_next   = scan_idx;
    have_held_next  = have_held;
    held_idx_next   = held_idx;
    fired_next      = 1'b0;
    fired_task_next = fired_task;
    last_next       = 1'b0;
    case (state)
      ST_IDLE: begin
        if (tok0) begin
          state_next     = ST_SCAN;
          scan_idx_next  = '0;
          have_held_next = 1'b0;
        end
      end
      ST_SCAN: begin
        if (hit_any) begin
          if (have_held) begin
            fired_next      = 1'b1;
            fired_task_next = held_idx;
          end
          held_idx_next  = scan_idx;
          have_held_next = 1'b1;
        end
        scan_idx_next = scan_idx + 1'b1;
        if (scan_idx == IDX_W'(TASK_COUNT - 1)) begin
          state_next = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (have_held) begin
          fired_next      = 1'b1;
          fired_task_next = held_idx;
          last_next       = 1'b1;
        end
        have_held_next = 1'b0;
        state_next     = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/ptdd_checker.sv
// Port-level checks for the periodic task deadline dispatcher, bound to the top.
// Depends on ptdd_pkg and periodic_task_deadline_dispatcher_macros.svh.
`include "periodic_task_deadline_dispatcher_macros.svh"

module ptdd_assertions import ptdd_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic [2:0] command,
  input logic       fired,
  input logic       last
);

  // Only the final result of a tick may land after busy drops.
  `PTDD_ASSERT_NOW(a_mid_result_busy, clk, rst, fired && !last, busy)
  // A table update finishes in its own cycle.
  `PTDD_ASSERT_NEXT(a_update_no_busy, clk, rst, start && !busy && (command != OP_TICK), !busy)
  // A tick always starts a scan.
  `PTDD_ASSERT_NEXT(a_tick_busy, clk, rst, start && !busy && (command == OP_TICK), busy)
  // Nothing follows the final result of a tick right away.
  `PTDD_ASSERT_NEXT(a_last_quiet, clk, rst, fired && last, !fired)

endmodule

bind periodic_task_deadline_dispatcher ptdd_assertions u_ptdd_assertions (.*);

>>> verif/ptdd_checker.sv
// Fired-task checker for the periodic task deadline dispatcher.
// Keeps its own copy of the task table, predicts the strobes of each tick
// request and compares them with the block's output. Depends on ptdd_pkg.
module ptdd_checker import ptdd_pkg::*; #(
  parameter int TASK_COUNT = TASK_COUNT_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              busy,
  input  logic [2:0]        command,
  input  logic [6:0]        task_index,
  input  logic [TIME_W-1:0] period,
  input  logic [TIME_W-1:0] now,
  input  logic              keep_enabled,
  input  logic              fired,
  input  logic [IDX_W-1:0]  fired_task,
  input  logic              last,
  output int                fail_count,
  output int                pending
);

  typedef struct packed {
    logic [IDX_W-1:0] task_id;
    logic             last;
  } fire_t;

  fire_t             expected_fires[$];
  logic              task_on       [TASK_COUNT];
  logic [TIME_W-1:0] task_interval [TASK_COUNT];
  logic [TIME_W-1:0] task_deadline [TASK_COUNT];
  logic              held          [TASK_COUNT];
  int                errors = 0;

  assign fail_count = errors;

  // Update the table for one accepted request; queue the strobes of a tick.
  task automatic apply_request(input logic [2:0] cmd, input logic [6:0] idx,
                               input logic [TIME_W-1:0] per,
                               input logic [TIME_W-1:0] at,
                               input logic keep);
    logic             single;
    logic             all;
    logic [IDX_W-1:0] hits[$];
    fire_t            f;
    single = idx < TASK_COUNT;
    all    = idx == TASK_COUNT;
    case (cmd)
      OP_TICK: begin
        for (int t = 0; t < TASK_COUNT; t++) begin
          if (task_on[t] && at >= task_deadline[t]) begin
            task_deadline[t] = at + task_interval[t];
            hits.push_back(IDX_W'(t));
          end
        end
        foreach (hits[k]) begin
          f.task_id = hits[k];
          f.last    = (k == hits.size() - 1);
          expected_fires.push_back(f);
        end
      end
      OP_SET: begin
        if (single) begin
          task_on[idx]       = 1'b1;
          task_interval[idx] = per;
          task_deadline[idx] = at + per;
        end
      end
      OP_CLEAR: begin
        if (single) task_on[idx] = 1'b0;
      end
      OP_SUSPEND: begin
        if (single) begin
          task_on[idx] = 1'b0;
        end else if (all) begin
          for (int t = 0; t < TASK_COUNT; t++) begin
            if (task_on[t]) begin
              held[t]    = 1'b1;
              task_on[t] = 1'b0;
            end
          end
        end
      end
      OP_RESUME: begin
        if (single) begin
          task_on[idx] = 1'b1;
        end else if (all) begin
          for (int t = 0; t < TASK_COUNT; t++) begin
            if (held[t]) begin
              held[t]    = 1'b0;
              task_on[t] = 1'b1;
            end
          end
        end
      end
      OP_REPORT: begin
        if (single) task_on[idx] = keep;
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    fire_t exp_fire;
    if (rst) begin
      for (int t = 0; t < TASK_COUNT; t++) begin
        task_on[t]       = 1'b0;
        task_interval[t] = '0;
        task_deadline[t] = '0;
        held[t]          = 1'b0;
      end
      expected_fires.delete();
    end else begin
      // Compare the strobe first: a request taken in this cycle only
      // produces strobes later.
      if (fired) begin
        if (expected_fires.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: unexpected strobe task %0d last %0b", fired_task, last);
        end else begin
          exp_fire = expected_fires.pop_front();
          if (fired_task !== exp_fire.task_id || last !== exp_fire.last) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: expected task %0d last %0b, got task %0d last %0b",
                       exp_fire.task_id, exp_fire.last, fired_task, last);
          end
        end
      end
      if (start && !busy)
        apply_request(command, task_index, period, now, keep_enabled);
    end
    pending <= expected_fires.size();
  end

endmodule

>>> verif/testbench.sv
// Top of the periodic task deadline dispatcher testbench.
// Drives directed and random requests into the block and gives the verdict;
// depends on ptdd_pkg, the block and ptdd_checker.
module testbench;
  import ptdd_pkg::*;

  localparam int         TASK_COUNT    = TASK_COUNT_DEFAULT;
  localparam logic [6:0] ALL_TASKS     = 7'(TASK_COUNT);
  localparam logic [2:0] CMD_SPARE_LO  = 3'd6;
  localparam logic [2:0] CMD_SPARE_HI  = 3'd7;
  localparam int         RANDOM_ITEMS  = 85;
  localparam int         QUIET_ITEMS   = 25;

  logic              clk          = 1'b0;
  logic              rst          = 1'b1;
  logic              start        = 1'b0;
  logic [2:0]        command      = '0;
  logic [6:0]        task_index   = '0;
  logic [TIME_W-1:0] period       = '0;
  logic [TIME_W-1:0] now          = '0;
  logic              keep_enabled = 1'b0;
  logic              busy;
  logic              fired;
  logic [IDX_W-1:0]  fired_task;
  logic              last;
  int                fail_count;
  int                pending;

  bit                allow_gaps = 1'b1;
  logic [TIME_W-1:0] sim_now;

  always #6 clk = ~clk;

  periodic_task_deadline_dispatcher #(.TASK_COUNT(TASK_COUNT)) dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .command(command), .task_index(task_index), .period(period), .now(now),
    .keep_enabled(keep_enabled),
    .fired(fired), .fired_task(fired_task), .last(last)
  );

  ptdd_checker #(.TASK_COUNT(TASK_COUNT)) checker_i (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .command(command), .task_index(task_index), .period(period), .now(now),
    .keep_enabled(keep_enabled),
    .fired(fired), .fired_task(fired_task), .last(last),
    .fail_count(fail_count), .pending(pending)
  );

  // Present one request, hold it until taken, then maybe idle a short burst.
  task automatic issue(input logic [2:0] cmd, input logic [6:0] idx,
                       input logic [TIME_W-1:0] per, input logic [TIME_W-1:0] at,
                       input logic keep);
    start        <= 1'b1;
    command      <= cmd;
    task_index   <= idx;
    period       <= per;
    now          <= at;
    keep_enabled <= keep;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (allow_gaps && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  function automatic logic [6:0] pick_group_index();
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) return 7'($urandom_range(0, TASK_COUNT - 1));
    if (r < 9) return ALL_TASKS;
    return 7'($urandom_range(TASK_COUNT + 1, 127));
  endfunction

  initial begin
    int                done;
    int                r;
    logic [TIME_W-1:0] per;
    logic [TIME_W-1:0] at;
    logic [6:0]        idx;

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed part
    issue(OP_TICK, 7'd0, '0, '0, 1'b0);           // empty table
    issue(OP_SET, 7'd0, '0, '0, 1'b0);
    issue(OP_SET, 7'd63, '1, '0, 1'b0);
    issue(OP_SET, 7'd5, 32'd3, 32'd10, 1'b1);
    issue(OP_TICK, 7'd0, '0, '1, 1'b0);           // three due, due of task 5 wraps
    issue(OP_TICK, 7'd0, '0, 32'd2, 1'b0);
    issue(OP_SET, ALL_TASKS, 32'd7, 32'd7, 1'b1); // out-of-range index: dropped
    issue(OP_SET, 7'h7f, 32'd1, 32'd1, 1'b1);
    issue(OP_CLEAR, ALL_TASKS, '0, '0, 1'b0);
    issue(OP_REPORT, ALL_TASKS, '0, '0, 1'b1);
    issue(OP_SUSPEND, 7'd5, '0, '0, 1'b0);
    issue(OP_SET, 7'd9, 32'd1, '0, 1'b0);
    issue(OP_SUSPEND, ALL_TASKS, '0, '0, 1'b0);
    issue(OP_TICK, 7'd0, '0, '1, 1'b0);           // everything suspended
    issue(OP_RESUME, 7'd5, '0, '0, 1'b0);
    issue(OP_RESUME, ALL_TASKS, '0, '0, 1'b0);
    issue(OP_SUSPEND, 7'd65, '0, '0, 1'b0);
    issue(OP_RESUME, 7'h7f, '0, '0, 1'b0);
    issue(OP_TICK, 7'd0, '0, '1, 1'b0);
    issue(OP_REPORT, 7'd0, '1, '1, 1'b0);
    issue(OP_REPORT, 7'd63, '0, '0, 1'b1);
    issue(CMD_SPARE_LO, 7'd3, '1, '1, 1'b1);
    issue(CMD_SPARE_HI, ALL_TASKS, '1, '1, 1'b1);
    issue(OP_CLEAR, 7'd63, '0, '0, 1'b0);
    issue(OP_TICK, 7'd0, '0, '1, 1'b0);

    // Random part: mostly sets and advancing ticks on a running time base
    sim_now = 32'd20;
    done = 0;
    while (done < RANDOM_ITEMS) begin
      if (done >= RANDOM_ITEMS - QUIET_ITEMS) allow_gaps = 1'b0;
      r = $urandom_range(0, 99);
      if (r < 35) begin
        r = $urandom_range(0, 9);
        if (r < 8)       per = 32'($urandom_range(0, 12));
        else if (r == 8) per = $urandom;
        else             per = $urandom_range(0, 1) ? '1 : '0;
        at = ($urandom_range(0, 19) == 0) ? $urandom : sim_now;
        issue(OP_SET, 7'($urandom_range(0, TASK_COUNT - 1)), per, at, 1'($urandom));
        done++;
      end else if (r < 65) begin
        sim_now = sim_now + 32'($urandom_range(0, 5));
        at = ($urandom_range(0, 19) == 0) ? $urandom : sim_now;
        issue(OP_TICK, 7'($urandom), $urandom, at, 1'($urandom));
        done++;
      end else if (r < 72) begin
        issue(OP_CLEAR, 7'($urandom_range(0, TASK_COUNT - 1)), $urandom, $urandom,
              1'($urandom));
        done++;
      end else if (r < 80) begin
        issue(OP_SUSPEND, pick_group_index(), $urandom, $urandom, 1'($urandom));
        done++;
      end else if (r < 88) begin
        issue(OP_RESUME, pick_group_index(), $urandom, $urandom, 1'($urandom));
        done++;
      end else if (r < 96) begin
        issue(OP_REPORT, 7'($urandom_range(0, TASK_COUNT - 1)), $urandom, $urandom,
              1'($urandom_range(0, 3) != 0));
        done++;
      end else begin
        // Noise: spare codes and out-of-range indexes, not counted
        r = $urandom_range(0, 3);
        idx = 7'($urandom_range(TASK_COUNT, 127));
        case (r)
          0: issue(CMD_SPARE_LO, 7'($urandom), $urandom, $urandom, 1'($urandom));
          1: issue(CMD_SPARE_HI, 7'($urandom), $urandom, $urandom, 1'($urandom));
          2: issue(OP_SET, idx, $urandom, $urandom, 1'($urandom));
          default: issue(OP_REPORT, idx, $urandom, $urandom, 1'($urandom));
        endcase
      end
    end
    start <= 1'b0;

    // Drain: every strobe in, scan finished, then a quiet stretch
    while (pending != 0 || busy) @(posedge clk);
    repeat (TASK_COUNT + 8) @(posedge clk);

    if (fail_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
